// ===== sv/ckh_pkg.sv =====
// Shared types and constants for the cuckoo hash set.
package ckh_pkg;

  // Key width is fixed by the item format.
  localparam int KEY_W = 32;
  localparam int LIMIT_W = 8;
  localparam int DEFAULT_SLOTS = 1024;
  localparam logic [LIMIT_W-1:0] KICK_LIMIT_RESET = 8'd32;

  // Operation codes; the unused code acts as a find.
  localparam logic [1:0] OP_FIND = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_DUP = 2'd2,
    STATUS_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_KICK
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic found;
    status_t status;
    logic [KEY_W-1:0] homeless_key;
  } out_item_t;

  // One table slot: occupied flag and stored key.
  typedef struct packed {
    logic valid;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Port strobes of one table memory.
  typedef struct packed {
    logic we;
    logic re;
  } tbl_ctl_t;

endpackage

// ===== sv/ckh_table.sv =====
// One table of the hash set: single-port-write, single-port-read slot memory.
module ckh_table
  import ckh_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic                     clk,
  input  tbl_ctl_t                 ctl,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [SLOTS];
  entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ckh_ctrl.sv =====
// Sequencer of the hash set: clear pass, lookup, erase, insert and kick chain.
module ckh_ctrl
  import ckh_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LIMIT_W-1:0]       cfg_data,
  output tbl_ctl_t                 t1_ctl,
  output logic [$clog2(SLOTS)-1:0] t1_waddr,
  output entry_t                   t1_wdata,
  output logic [$clog2(SLOTS)-1:0] t1_raddr,
  input  entry_t                   t1_rdata,
  output tbl_ctl_t                 t2_ctl,
  output logic [$clog2(SLOTS)-1:0] t2_waddr,
  output entry_t                   t2_wdata,
  output logic [$clog2(SLOTS)-1:0] t2_raddr,
  input  entry_t                   t2_rdata
);

  localparam int IDX_BITS = $clog2(SLOTS);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

  state_t state_r, state_nxt;
  logic [IDX_BITS-1:0] clr_r, clr_nxt;
  logic [1:0] op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] hand_r, hand_nxt;
  logic to_second_r, to_second_nxt;
  logic [LIMIT_W-1:0] kicks_r, kicks_nxt;
  logic [LIMIT_W-1:0] kick_limit_r;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic can_emit;
  logic hit1, hit2;
  entry_t old;

  // Home slots in each table: low index bits, then the next index bits.
  function automatic logic [IDX_BITS-1:0] idx_first(input logic [KEY_W-1:0] k);
    return k[IDX_BITS-1:0];
  endfunction

  function automatic logic [IDX_BITS-1:0] idx_second(input logic [KEY_W-1:0] k);
    return k[2*IDX_BITS-1:IDX_BITS];
  endfunction

  function automatic out_item_t result(input logic f, input status_t s,
                                       input logic [KEY_W-1:0] h);
    out_item_t r;
    r.found = f;
    r.status = s;
    r.homeless_key = h;
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // A new result may be loaded when the output register is empty or draining.
  assign can_emit = !out_valid_r || !out_stall;
  assign hit1 = t1_rdata.valid && (t1_rdata.key == key_r);
  assign hit2 = t2_rdata.valid && (t2_rdata.key == key_r);
  assign old = to_second_r ? t2_rdata : t1_rdata;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kick_limit_r <= KICK_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      kick_limit_r <= cfg_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    key_r <= key_nxt;
    hand_r <= hand_nxt;
    to_second_r <= to_second_nxt;
    kicks_r <= kicks_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state, memory strobes and result.
  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    op_nxt = op_r;
    key_nxt = key_r;
    hand_nxt = hand_r;
    to_second_nxt = to_second_r;
    kicks_nxt = kicks_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    in_stall = 1'b1;
    t1_ctl = '0;
    t2_ctl = '0;
    t1_waddr = idx_first(key_r);
    t2_waddr = idx_second(key_r);
    t1_wdata = '0;
    t2_wdata = '0;
    t1_raddr = idx_first(in_data.key);
    t2_raddr = idx_second(in_data.key);

    unique case (state_r)
      // Sweep both tables once after reset, marking every slot empty.
      ST_CLEAR: begin
        t1_ctl.we = 1'b1;
        t2_ctl.we = 1'b1;
        t1_waddr = clr_r;
        t2_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take a beat and read both home slots.
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          t1_ctl.re = 1'b1;
          t2_ctl.re = 1'b1;
          op_nxt = in_data.op;
          key_nxt = in_data.key;
          state_nxt = ST_LOOK;
        end
      end

      // Home slot contents are here: decide the operation.
      ST_LOOK: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
          if (op_r == OP_ERASE) begin
            if (hit1) begin
              t1_ctl.we = 1'b1;
            end else if (hit2) begin
              t2_ctl.we = 1'b1;
            end
            out_valid_nxt = 1'b1;
            out_data_nxt = result(hit1 || hit2,
                                  (hit1 || hit2) ? STATUS_DONE : STATUS_ABSENT, '0);
          end else if (op_r != OP_INSERT) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = result(hit1 || hit2,
                                  (hit1 || hit2) ? STATUS_DONE : STATUS_ABSENT, '0);
          end else if (hit1 || hit2) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = result(1'b1, STATUS_DUP, '0);
          end else if (!t1_rdata.valid) begin
            t1_ctl.we = 1'b1;
            t1_wdata = '{valid: 1'b1, key: key_r};
            out_valid_nxt = 1'b1;
            out_data_nxt = result(1'b0, STATUS_DONE, '0);
          end else if (!t2_rdata.valid) begin
            t2_ctl.we = 1'b1;
            t2_wdata = '{valid: 1'b1, key: key_r};
            out_valid_nxt = 1'b1;
            out_data_nxt = result(1'b0, STATUS_DONE, '0);
          end else begin
            // Both homes taken: start the chain in the second table, whose
            // slot content is still held in its read register.
            hand_nxt = key_r;
            to_second_nxt = 1'b1;
            kicks_nxt = '0;
            state_nxt = ST_KICK;
          end
        end
      end

      // One swap per cycle while the output register can take a result: place the
      // key in hand, pick up the old one and read its slot in the other table.
      ST_KICK: begin
        if (can_emit) begin
          if (kicks_r >= kick_limit_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = result(1'b0, STATUS_FULL, hand_r);
            state_nxt = ST_IDLE;
          end else begin
            if (to_second_r) begin
              t2_ctl.we = 1'b1;
              t2_waddr = idx_second(hand_r);
              t2_wdata = '{valid: 1'b1, key: hand_r};
            end else begin
              t1_ctl.we = 1'b1;
              t1_waddr = idx_first(hand_r);
              t1_wdata = '{valid: 1'b1, key: hand_r};
            end
            kicks_nxt = kicks_r + 1'b1;
            if (!old.valid) begin
              out_valid_nxt = 1'b1;
              out_data_nxt = result(1'b0, STATUS_DONE, '0);
              state_nxt = ST_IDLE;
            end else if (old.key == key_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt = result(1'b0, STATUS_FULL, key_r);
              state_nxt = ST_IDLE;
            end else begin
              hand_nxt = old.key;
              to_second_nxt = !to_second_r;
              if (to_second_r) begin
                t1_ctl.re = 1'b1;
                t1_raddr = idx_first(old.key);
              end else begin
                t2_ctl.re = 1'b1;
                t2_raddr = idx_second(old.key);
              end
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/cuckoo_hash_set.sv =====
// Cuckoo hash set of 32-bit keys: two slot tables and their sequencer.
//
// Two-table cuckoo hash set. Each input beat is a find, erase or insert of one
// key; each produces exactly one result beat. The first table is indexed by the
// key's low log2(SLOTS) bits, the second by the next log2(SLOTS) bits, so SLOTS
// must be a power of two no larger than 65536. After reset the block sweeps
// both tables to mark every slot empty, one slot per cycle, and holds in_stall
// high until the sweep is done. The kick_limit register takes a write in any
// cycle, but a kick chain that is running sees the new value at once, so write
// it only while no item is in flight. Once running, items are handled one at a
// time: find, erase and inserts that settle in a home slot take the accept and
// one table read. An insert that displaces keys goes on with swaps until it
// ends in an empty slot or with the new key pushed back out, or until the
// kick limit stops it; each swap is one read-modify-write of the alternate
// table through its registered read port. A finished result sits in an output
// register, so the next beat is accepted while it waits to be taken.
module cuckoo_hash_set
  import ckh_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int IDX_BITS = $clog2(SLOTS);

  tbl_ctl_t t1_ctl, t2_ctl;
  logic [IDX_BITS-1:0] t1_waddr, t1_raddr, t2_waddr, t2_raddr;
  entry_t t1_wdata, t1_rdata, t2_wdata, t2_rdata;

  // Sequencer.
  ckh_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .t1_ctl(t1_ctl),
    .t1_waddr(t1_waddr),
    .t1_wdata(t1_wdata),
    .t1_raddr(t1_raddr),
    .t1_rdata(t1_rdata),
    .t2_ctl(t2_ctl),
    .t2_waddr(t2_waddr),
    .t2_wdata(t2_wdata),
    .t2_raddr(t2_raddr),
    .t2_rdata(t2_rdata)
  );

  // First table.
  ckh_table #(
    .SLOTS(SLOTS)
  ) u_first (
    .clk(clk),
    .ctl(t1_ctl),
    .waddr(t1_waddr),
    .wdata(t1_wdata),
    .raddr(t1_raddr),
    .rdata(t1_rdata)
  );

  // Second table.
  ckh_table #(
    .SLOTS(SLOTS)
  ) u_second (
    .clk(clk),
    .ctl(t2_ctl),
    .waddr(t2_waddr),
    .wdata(t2_wdata),
    .raddr(t2_raddr),
    .rdata(t2_rdata)
  );

endmodule
